>>> rtl/pdbs_pkg.sv
// Shared types, constants and fixed-point helpers for the projectile step block.
// Used by pdbs_isqrt and projectile_drag_bounce_step; depends on nothing else.

package pdbs_pkg;

  // Default number of fraction bits of the state format (Q20.12).
  localparam int FRAC_BITS_DEF = 12;
  // Fraction bits of the time step (unsigned Q4.12).
  localparam int TS_FRAC = 12;
  // Fraction bits of the bounce and friction factors (Q0.16).
  localparam int FACTOR_FRAC = 16;
  localparam logic [31:0] BOUNCE_Q16   = 32'd39322;
  localparam logic [31:0] FRICTION_Q16 = 32'd58982;

  // Whole-pixel reset values of the particle state.
  localparam int POS_X_RST = 640;
  localparam int POS_Y_RST = 400;
  localparam int VEL_X_RST = 10;
  localparam int VEL_Y_RST = 12;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEFF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd5;

  // Configuration reset values.
  localparam logic [15:0] DRAG_COEFF_RST    = 16'd328;
  localparam logic [11:0] GRAVITY_RST       = 12'd300;
  localparam logic [11:0] ARENA_WIDTH_RST   = 12'd1280;
  localparam logic [11:0] ARENA_HEIGHT_RST  = 12'd800;
  localparam logic [11:0] SPRITE_WIDTH_RST  = 12'd96;
  localparam logic [11:0] SPRITE_HEIGHT_RST = 12'd96;

  // Operation codes carried in the input tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Number of iterations of the square root unit, one result bit each.
  localparam int SQRT_STEPS = 32;

  localparam logic signed [65:0] S32_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] S32_MIN = -66'sh0_8000_0000;

  // A 32-bit value together with a flag that says it was clipped.
  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } sat_t;

  // Request to the square root unit.
  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  // Response of the square root unit; root is valid while done is high.
  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  // Clip a wide signed value to the signed 32-bit range.
  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > S32_MAX) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r.clip = 1'b1;
      r.val  = 32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value gives 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Floored right shift of a signed value given as sign and magnitude.
  function automatic logic signed [65:0] floor_shift(input logic [63:0] m,
                                                     input logic        neg,
                                                     input logic [4:0]  s);
    logic [64:0] mask;
    logic [64:0] q;
    mask = (65'd1 << s) - 65'd1;
    q    = neg ? ((65'(m) + mask) >> s) : (65'(m) >> s);
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

>>> rtl/pdbs_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
// Stand-alone; instantiated by projectile_drag_bounce_step.

module pdbs_mul (
  input  logic        clk,
  input  logic [31:0] mul_a,
  input  logic [31:0] mul_b,
  output logic [63:0] prod_r
);

  logic [63:0] prod_nxt;

  // One product per cycle, ready for the sequencer in the next cycle.
  assign prod_nxt = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

>>> rtl/pdbs_isqrt.sv
// Iterative floored integer square root of a 64-bit value, one root bit a cycle.
// Depends on pdbs_pkg for the request and response types.

module pdbs_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  pdbs_pkg::sqrt_req_t req,
  output pdbs_pkg::sqrt_rsp_t rsp
);

  localparam int CNT_W = $clog2(pdbs_pkg::SQRT_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pdbs_pkg::SQRT_STEPS - 1);
  localparam logic [63:0] BIT_START = 64'd1 << (2 * pdbs_pkg::SQRT_STEPS - 2);

  logic [63:0]      rem_r, rem_nxt;
  logic [63:0]      res_r, res_nxt;
  logic [63:0]      bit_r, bit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // Restoring square root: try res + bit against the remainder each step.
  always_comb begin
    logic [63:0] trial;
    trial    = res_r + bit_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.radicand;
      res_nxt  = 64'd0;
      bit_nxt  = BIT_START;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];

endmodule

>>> rtl/projectile_drag_bounce_step.sv
// Projectile step with quadratic drag, gravity and bouncing walls.
// Depends on pdbs_pkg, pdbs_mul and pdbs_isqrt.
//
// Usage: one particle's position and velocity live in the block. Requests
// arrive on the in_ stream; in_tuser selects a tick (0) or a load (1), and
// in_tdata carries the time step and the load values. Each request gives
// exactly one result on the out_ stream: the new state, the acceleration
// used and the bounce and saturation flags.
// The cfg_ channel writes the six setup registers; it is always ready. The user
// must see that it is written only while no request is in flight; the block itself does not enforce this.
// Sequence: a load goes straight to the hand-off. A tick runs the wall rules
// and squares, the square root unit (its start plus one root bit per cycle)
// and then drag, the Euler update and the hand-off, all multiplies sharing one
// 32x32 multiplier. A new request is taken only once the sequencer is idle
// again, after the previous request has been handed off.
// The finished result sits in an output register; the next request is taken
// while it waits. Should a later result finish while the receiver still
// stalls, the sequencer holds it until the register frees.
// Reset (synchronous, rst_n low) restores the setup registers and the state
// to 640.0, 400.0, 10.0, 12.0 and clears all pending work.

module projectile_drag_bounce_step #(
  parameter int FRAC_BITS = pdbs_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata, low bit up: time_step[16], load_pos_x[32], load_pos_y[32],
  // load_vel_x[32], load_vel_y[32].
  input  logic [143:0]                     in_tdata,
  // tuser: operation[1].
  input  logic [0:0]                       in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata, low bit up: out_pos_x[32], out_pos_y[32], out_vel_x[32],
  // out_vel_y[32], accel_x[32], accel_y[32], bounced[1], saturated[1], zeros[6].
  output logic [199:0]                     out_tdata,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pdbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data
);

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WALL = 5'd1;
  localparam logic [4:0] S_TOP  = 5'd2;
  localparam logic [4:0] S_TOPW = 5'd3;
  localparam logic [4:0] S_FLR1 = 5'd4;
  localparam logic [4:0] S_FLR2 = 5'd5;
  localparam logic [4:0] S_FLR3 = 5'd6;
  localparam logic [4:0] S_SQX  = 5'd7;
  localparam logic [4:0] S_SQY  = 5'd8;
  localparam logic [4:0] S_SQS  = 5'd9;
  localparam logic [4:0] S_ROOT = 5'd10;
  localparam logic [4:0] S_KS   = 5'd11;
  localparam logic [4:0] S_DX   = 5'd12;
  localparam logic [4:0] S_DY   = 5'd13;
  localparam logic [4:0] S_HAX  = 5'd14;
  localparam logic [4:0] S_HAY  = 5'd15;
  localparam logic [4:0] S_HVX  = 5'd16;
  localparam logic [4:0] S_HVY  = 5'd17;
  localparam logic [4:0] S_FIN  = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  localparam logic [31:0] PX_RST = 32'(pdbs_pkg::POS_X_RST) << FRAC_BITS;
  localparam logic [31:0] PY_RST = 32'(pdbs_pkg::POS_Y_RST) << FRAC_BITS;
  localparam logic [31:0] VX_RST = 32'(pdbs_pkg::VEL_X_RST) << FRAC_BITS;
  localparam logic [31:0] VY_RST = 32'(pdbs_pkg::VEL_Y_RST) << FRAC_BITS;

  localparam logic [4:0] SH_FACTOR = 5'(pdbs_pkg::FACTOR_FRAC);
  localparam logic [4:0] SH_TS     = 5'(pdbs_pkg::TS_FRAC);

  logic [4:0]         state_r, state_nxt;

  // Setup registers.
  logic [15:0]        drag_r;
  logic [11:0]        grav_r, aw_r, ah_r, sw_r, sh_r;

  // Particle state and work registers.
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [31:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [31:0] nvx_r, nvx_nxt, nvy_r, nvy_nxt, npx_r, npx_nxt;
  logic [15:0]        h_r, h_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [31:0]        ks_r, ks_nxt;
  logic               top_hit_r, top_hit_nxt, flr_hit_r, flr_hit_nxt;
  logic               bounce_r, bounce_nxt, sat_r, sat_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [199:0]       out_data_r, out_data_nxt;

  // Shared units.
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         prod_r;
  pdbs_pkg::sqrt_req_t sq_req;
  pdbs_pkg::sqrt_rsp_t sq_rsp;

  // Wall rule results.
  logic signed [31:0] wall_px, wall_py, wall_vx;
  logic               wall_top, wall_flr, wall_any, wall_clip;

  pdbs_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod_r(prod_r)
  );

  pdbs_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .rsp  (sq_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Side walls clamp x and negate vx; top and floor clamp y and flag the scaling.
  always_comb begin
    logic signed [33:0] right_s, top_s, floor_s, x_s, y_s;
    pdbs_pkg::sat_t     n1, n2;
    right_s   = ($signed({22'd0, aw_r}) - $signed({22'd0, sw_r})) <<< FRAC_BITS;
    top_s     = $signed({22'd0, ah_r}) <<< FRAC_BITS;
    floor_s   = $signed({22'd0, sh_r}) <<< FRAC_BITS;
    x_s       = 34'(px_r);
    y_s       = 34'(py_r);
    n1        = '0;
    n2        = '0;
    wall_vx   = vx_r;
    wall_clip = 1'b0;
    wall_any  = 1'b0;
    wall_top  = 1'b0;
    wall_flr  = 1'b0;
    if (x_s >= right_s) begin
      x_s       = right_s;
      n1        = pdbs_pkg::sat32(-66'(wall_vx));
      wall_vx   = n1.val;
      wall_clip = wall_clip | n1.clip;
      wall_any  = 1'b1;
    end
    if (x_s <= 34'sd0) begin
      x_s       = 34'sd0;
      n2        = pdbs_pkg::sat32(-66'(wall_vx));
      wall_vx   = n2.val;
      wall_clip = wall_clip | n2.clip;
      wall_any  = 1'b1;
    end
    if (y_s >= top_s) begin
      y_s      = top_s;
      wall_top = 1'b1;
      wall_any = 1'b1;
    end
    if (y_s <= floor_s) begin
      y_s      = floor_s;
      wall_flr = 1'b1;
      wall_any = 1'b1;
    end
    wall_px = x_s[31:0];
    wall_py = y_s[31:0];
  end

  // Sequencer: each state may take the last product and issue the next one.
  always_comb begin
    logic signed [65:0] fs;
    logic signed [65:0] drag;
    logic [63:0]        dmag;
    logic [65:0]        g_ext;
    pdbs_pkg::sat_t     s;
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    nvx_nxt       = nvx_r;
    nvy_nxt       = nvy_r;
    npx_nxt       = npx_r;
    h_nxt         = h_r;
    sum_nxt       = sum_r;
    ks_nxt        = ks_r;
    top_hit_nxt   = top_hit_r;
    flr_hit_nxt   = flr_hit_r;
    bounce_nxt    = bounce_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    mul_a         = 32'd0;
    mul_b         = 32'd0;
    sq_req.start    = 1'b0;
    sq_req.radicand = sum_r + prod_r;
    dmag          = prod_r >> FRAC_BITS;
    g_ext         = 66'(grav_r) << FRAC_BITS;
    fs            = '0;
    drag          = '0;
    s             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == pdbs_pkg::OP_LOAD) begin
            px_nxt    = in_tdata[47:16];
            py_nxt    = in_tdata[79:48];
            vx_nxt    = in_tdata[111:80];
            vy_nxt    = in_tdata[143:112];
            ax_nxt    = 32'sd0;
            ay_nxt    = 32'sd0;
            bounce_nxt = 1'b0;
            sat_nxt    = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            h_nxt      = in_tdata[15:0];
            bounce_nxt = 1'b0;
            sat_nxt    = 1'b0;
            state_nxt  = S_WALL;
          end
        end
      end
      S_WALL: begin
        px_nxt      = wall_px;
        py_nxt      = wall_py;
        vx_nxt      = wall_vx;
        top_hit_nxt = wall_top;
        flr_hit_nxt = wall_flr;
        bounce_nxt  = wall_any;
        sat_nxt     = sat_r | wall_clip;
        state_nxt   = S_TOP;
      end
      S_TOP: begin
        mul_a     = pdbs_pkg::mag32(vy_r);
        mul_b     = pdbs_pkg::BOUNCE_Q16;
        state_nxt = S_TOPW;
      end
      S_TOPW: begin
        // Top wall: vy becomes minus the floored product with 0.6.
        fs = pdbs_pkg::floor_shift(prod_r, vy_r[31], SH_FACTOR);
        if (top_hit_r) begin
          vy_nxt = 32'(-fs);
        end
        state_nxt = S_FLR1;
      end
      S_FLR1: begin
        mul_a     = pdbs_pkg::mag32(vy_r);
        mul_b     = pdbs_pkg::BOUNCE_Q16;
        state_nxt = S_FLR2;
      end
      S_FLR2: begin
        fs = pdbs_pkg::floor_shift(prod_r, vy_r[31], SH_FACTOR);
        if (flr_hit_r) begin
          vy_nxt = 32'(-fs);
        end
        mul_a     = pdbs_pkg::mag32(vx_r);
        mul_b     = pdbs_pkg::FRICTION_Q16;
        state_nxt = S_FLR3;
      end
      S_FLR3: begin
        // Floor friction: vx scaled by 0.9 and floored.
        fs = pdbs_pkg::floor_shift(prod_r, vx_r[31], SH_FACTOR);
        if (flr_hit_r) begin
          vx_nxt = fs[31:0];
        end
        state_nxt = S_SQX;
      end
      S_SQX: begin
        mul_a     = pdbs_pkg::mag32(vx_r);
        mul_b     = pdbs_pkg::mag32(vx_r);
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sum_nxt   = prod_r;
        mul_a     = pdbs_pkg::mag32(vy_r);
        mul_b     = pdbs_pkg::mag32(vy_r);
        state_nxt = S_SQS;
      end
      S_SQS: begin
        sq_req.start = 1'b1;
        state_nxt    = S_ROOT;
      end
      S_ROOT: begin
        if (sq_rsp.done) begin
          mul_a     = {16'd0, drag_r};
          mul_b     = sq_rsp.root;
          state_nxt = S_KS;
        end
      end
      S_KS: begin
        ks_nxt    = prod_r[47:16];
        state_nxt = S_DX;
      end
      S_DX: begin
        mul_a     = pdbs_pkg::mag32(vx_r);
        mul_b     = ks_r;
        state_nxt = S_DY;
      end
      S_DY: begin
        // Drag takes the sign opposite to the velocity component.
        drag      = vx_r[31] ? $signed({2'b00, dmag}) : -$signed({2'b00, dmag});
        s         = pdbs_pkg::sat32(drag);
        ax_nxt    = s.val;
        sat_nxt   = sat_r | s.clip;
        mul_a     = pdbs_pkg::mag32(vy_r);
        mul_b     = ks_r;
        state_nxt = S_HAX;
      end
      S_HAX: begin
        drag      = vy_r[31] ? $signed({2'b00, dmag}) : -$signed({2'b00, dmag});
        s         = pdbs_pkg::sat32(drag - $signed(g_ext));
        ay_nxt    = s.val;
        sat_nxt   = sat_r | s.clip;
        mul_a     = {16'd0, h_r};
        mul_b     = pdbs_pkg::mag32(ax_r);
        state_nxt = S_HAY;
      end
      S_HAY: begin
        fs        = pdbs_pkg::floor_shift(prod_r, ax_r[31], SH_TS);
        s         = pdbs_pkg::sat32(66'(vx_r) + fs);
        nvx_nxt   = s.val;
        sat_nxt   = sat_r | s.clip;
        mul_a     = {16'd0, h_r};
        mul_b     = pdbs_pkg::mag32(ay_r);
        state_nxt = S_HVX;
      end
      S_HVX: begin
        fs        = pdbs_pkg::floor_shift(prod_r, ay_r[31], SH_TS);
        s         = pdbs_pkg::sat32(66'(vy_r) + fs);
        nvy_nxt   = s.val;
        sat_nxt   = sat_r | s.clip;
        mul_a     = {16'd0, h_r};
        mul_b     = pdbs_pkg::mag32(vx_r);
        state_nxt = S_HVY;
      end
      S_HVY: begin
        fs        = pdbs_pkg::floor_shift(prod_r, vx_r[31], SH_TS);
        s         = pdbs_pkg::sat32(66'(px_r) + fs);
        npx_nxt   = s.val;
        sat_nxt   = sat_r | s.clip;
        mul_a     = {16'd0, h_r};
        mul_b     = pdbs_pkg::mag32(vy_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Commit the Euler step.
        fs        = pdbs_pkg::floor_shift(prod_r, vy_r[31], SH_TS);
        s         = pdbs_pkg::sat32(66'(py_r) + fs);
        py_nxt    = s.val;
        sat_nxt   = sat_r | s.clip;
        px_nxt    = npx_r;
        vx_nxt    = nvx_r;
        vy_nxt    = nvy_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, sat_r, bounce_r, ay_r, ax_r, vy_r, vx_r, py_r, px_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control, state and setup registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      px_r        <= PX_RST;
      py_r        <= PY_RST;
      vx_r        <= VX_RST;
      vy_r        <= VY_RST;
      drag_r      <= pdbs_pkg::DRAG_COEFF_RST;
      grav_r      <= pdbs_pkg::GRAVITY_RST;
      aw_r        <= pdbs_pkg::ARENA_WIDTH_RST;
      ah_r        <= pdbs_pkg::ARENA_HEIGHT_RST;
      sw_r        <= pdbs_pkg::SPRITE_WIDTH_RST;
      sh_r        <= pdbs_pkg::SPRITE_HEIGHT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      vx_r        <= vx_nxt;
      vy_r        <= vy_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          pdbs_pkg::CFG_DRAG_COEFF:    drag_r <= cfg_data;
          pdbs_pkg::CFG_GRAVITY:       grav_r <= cfg_data[11:0];
          pdbs_pkg::CFG_ARENA_WIDTH:   aw_r   <= cfg_data[11:0];
          pdbs_pkg::CFG_ARENA_HEIGHT:  ah_r   <= cfg_data[11:0];
          pdbs_pkg::CFG_SPRITE_WIDTH:  sw_r   <= cfg_data[11:0];
          pdbs_pkg::CFG_SPRITE_HEIGHT: sh_r   <= cfg_data[11:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Work and payload registers.
  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    nvx_r      <= nvx_nxt;
    nvy_r      <= nvy_nxt;
    npx_r      <= npx_nxt;
    h_r        <= h_nxt;
    sum_r      <= sum_nxt;
    ks_r       <= ks_nxt;
    top_hit_r  <= top_hit_nxt;
    flr_hit_r  <= flr_hit_nxt;
    bounce_r   <= bounce_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
